@@ sv/lcg64_with_jump_ahead_top_macros.svh @@
// Assertion macros used by the checker file of this block.
`ifndef LCG64_WITH_JUMP_AHEAD_TOP_MACROS_SVH
`define LCG64_WITH_JUMP_AHEAD_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define LCG64_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define LCG64_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/lcg64_pkg.sv @@
package lcg64_pkg;

  localparam logic [63:0] LCG_MUL  = 64'd6364136223846793005;
  localparam logic [63:0] LCG_INC  = 64'd1;
  localparam logic [63:0] SEED_RST = 64'd1;
  localparam logic [63:0] ST_RST   = LCG_MUL * (~SEED_RST) + LCG_INC;

  localparam logic [1:0] CMD_DRAW    = 2'd0;
  localparam logic [1:0] CMD_SKIP    = 2'd1;
  localparam logic [1:0] CMD_RESEED  = 2'd2;
  localparam logic [1:0] CMD_IGNORED = 2'd3;

  localparam logic [1:0] FMT_ABS32 = 2'd0;
  localparam logic [1:0] FMT_ABS64 = 2'd1;

  localparam logic REG_SEED   = 1'b0;
  localparam logic REG_FORMAT = 1'b1;

  localparam logic [1:0] PH_NONE = 2'd0;
  localparam logic [1:0] PH_P0   = 2'd1;
  localparam logic [1:0] PH_P1   = 2'd2;
  localparam logic [1:0] PH_P2   = 2'd3;

  localparam logic [1:0] X_ST    = 2'd0;
  localparam logic [1:0] X_NSEED = 2'd1;
  localparam logic [1:0] X_JA    = 2'd2;
  localparam logic [1:0] X_SA    = 2'd3;

  localparam logic [1:0] Y_A  = 2'd0;
  localparam logic [1:0] Y_SC = 2'd1;
  localparam logic [1:0] Y_SA = 2'd2;
  localparam logic [1:0] Y_ST = 2'd3;

  localparam logic [1:0] Z_ONE  = 2'd0;
  localparam logic [1:0] Z_JC   = 2'd1;
  localparam logic [1:0] Z_SC   = 2'd2;
  localparam logic [1:0] Z_ZERO = 2'd3;

  localparam logic [2:0] D_NONE = 3'd0;
  localparam logic [2:0] D_ST   = 3'd1;
  localparam logic [2:0] D_JA   = 3'd2;
  localparam logic [2:0] D_JC   = 3'd3;
  localparam logic [2:0] D_SA   = 3'd4;
  localparam logic [2:0] D_SC   = 3'd5;

  localparam logic [2:0] J_SEQ   = 3'd0;
  localparam logic [2:0] J_JZ    = 3'd1;
  localparam logic [2:0] J_JEVEN = 3'd2;
  localparam logic [2:0] J_JMP   = 3'd3;
  localparam logic [2:0] J_END   = 3'd4;

  localparam logic [4:0] PC_DRAW   = 5'd0;
  localparam logic [4:0] PC_RESEED = 5'd4;
  localparam logic [4:0] PC_SKIP   = 5'd8;
  localparam logic [4:0] PC_TEST   = 5'd9;
  localparam logic [4:0] PC_SQUARE = 5'd19;
  localparam logic [4:0] PC_FINAL  = 5'd27;

  typedef struct packed {
    logic [1:0] phase;
    logic [1:0] xsel;
    logic [1:0] ysel;
    logic [1:0] zsel;
    logic [2:0] dst;
    logic [2:0] jmp;
    logic [4:0] target;
    logic       init;
    logic       shift;
    logic       emit;
  } uword_t;

  function automatic uword_t uw(input logic [1:0] phase, input logic [1:0] xsel,
                                input logic [1:0] ysel, input logic [1:0] zsel,
                                input logic [2:0] dst, input logic [2:0] jmp,
                                input logic [4:0] target, input logic init,
                                input logic shift, input logic emit);
    uword_t w;
    w.phase  = phase;
    w.xsel   = xsel;
    w.ysel   = ysel;
    w.zsel   = zsel;
    w.dst    = dst;
    w.jmp    = jmp;
    w.target = target;
    w.init   = init;
    w.shift  = shift;
    w.emit   = emit;
    return w;
  endfunction

  function automatic uword_t ucode_rom(input logic [4:0] pc);
    uword_t w;
    case (pc)
      // Draw: emit the formatted state, then state = A * state + 1.
      5'd0:  w = uw(PH_P0, X_ST, Y_A, Z_ONE, D_NONE, J_SEQ, 5'd0, 1'b0, 1'b0, 1'b1);
      5'd1:  w = uw(PH_P1, X_ST, Y_A, Z_ONE, D_NONE, J_SEQ, 5'd0, 1'b0, 1'b0, 1'b0);
      5'd2:  w = uw(PH_P2, X_ST, Y_A, Z_ONE, D_NONE, J_SEQ, 5'd0, 1'b0, 1'b0, 1'b0);
      5'd3:  w = uw(PH_NONE, X_ST, Y_A, Z_ONE, D_ST, J_END, 5'd0, 1'b0, 1'b0, 1'b0);
      // Reseed: state = A * ~seed + 1.
      5'd4:  w = uw(PH_P0, X_NSEED, Y_A, Z_ONE, D_NONE, J_SEQ, 5'd0, 1'b0, 1'b0, 1'b0);
      5'd5:  w = uw(PH_P1, X_NSEED, Y_A, Z_ONE, D_NONE, J_SEQ, 5'd0, 1'b0, 1'b0, 1'b0);
      5'd6:  w = uw(PH_P2, X_NSEED, Y_A, Z_ONE, D_NONE, J_SEQ, 5'd0, 1'b0, 1'b0, 1'b0);
      5'd7:  w = uw(PH_NONE, X_ST, Y_A, Z_ONE, D_ST, J_END, 5'd0, 1'b0, 1'b0, 1'b0);
      // Skip: initialize the coefficient pairs, then loop over count bits.
      5'd8:  w = uw(PH_NONE, X_ST, Y_A, Z_ONE, D_NONE, J_SEQ, 5'd0, 1'b1, 1'b0, 1'b0);
      5'd9:  w = uw(PH_NONE, X_ST, Y_A, Z_ONE, D_NONE, J_JZ, PC_FINAL, 1'b0, 1'b0, 1'b0);
      5'd10: w = uw(PH_NONE, X_ST, Y_A, Z_ONE, D_NONE, J_JEVEN, PC_SQUARE,
                    1'b0, 1'b0, 1'b0);
      5'd11: w = uw(PH_P0, X_JA, Y_SC, Z_JC, D_NONE, J_SEQ, 5'd0, 1'b0, 1'b0, 1'b0);
      5'd12: w = uw(PH_P1, X_JA, Y_SC, Z_JC, D_NONE, J_SEQ, 5'd0, 1'b0, 1'b0, 1'b0);
      5'd13: w = uw(PH_P2, X_JA, Y_SC, Z_JC, D_NONE, J_SEQ, 5'd0, 1'b0, 1'b0, 1'b0);
      5'd14: w = uw(PH_NONE, X_ST, Y_A, Z_ONE, D_JC, J_SEQ, 5'd0, 1'b0, 1'b0, 1'b0);
      5'd15: w = uw(PH_P0, X_JA, Y_SA, Z_ZERO, D_NONE, J_SEQ, 5'd0, 1'b0, 1'b0, 1'b0);
      5'd16: w = uw(PH_P1, X_JA, Y_SA, Z_ZERO, D_NONE, J_SEQ, 5'd0, 1'b0, 1'b0, 1'b0);
      5'd17: w = uw(PH_P2, X_JA, Y_SA, Z_ZERO, D_NONE, J_SEQ, 5'd0, 1'b0, 1'b0, 1'b0);
      5'd18: w = uw(PH_NONE, X_ST, Y_A, Z_ONE, D_JA, J_SEQ, 5'd0, 1'b0, 1'b0, 1'b0);
      5'd19: w = uw(PH_P0, X_SA, Y_SC, Z_SC, D_NONE, J_SEQ, 5'd0, 1'b0, 1'b0, 1'b0);
      5'd20: w = uw(PH_P1, X_SA, Y_SC, Z_SC, D_NONE, J_SEQ, 5'd0, 1'b0, 1'b0, 1'b0);
      5'd21: w = uw(PH_P2, X_SA, Y_SC, Z_SC, D_NONE, J_SEQ, 5'd0, 1'b0, 1'b0, 1'b0);
      5'd22: w = uw(PH_NONE, X_ST, Y_A, Z_ONE, D_SC, J_SEQ, 5'd0, 1'b0, 1'b0, 1'b0);
      5'd23: w = uw(PH_P0, X_SA, Y_SA, Z_ZERO, D_NONE, J_SEQ, 5'd0, 1'b0, 1'b0, 1'b0);
      5'd24: w = uw(PH_P1, X_SA, Y_SA, Z_ZERO, D_NONE, J_SEQ, 5'd0, 1'b0, 1'b0, 1'b0);
      5'd25: w = uw(PH_P2, X_SA, Y_SA, Z_ZERO, D_NONE, J_SEQ, 5'd0, 1'b0, 1'b0, 1'b0);
      5'd26: w = uw(PH_NONE, X_ST, Y_A, Z_ONE, D_SA, J_JMP, PC_TEST, 1'b0, 1'b1, 1'b0);
      // Apply the composed jump: state = ja * state + jc.
      5'd27: w = uw(PH_P0, X_JA, Y_ST, Z_JC, D_NONE, J_SEQ, 5'd0, 1'b0, 1'b0, 1'b0);
      5'd28: w = uw(PH_P1, X_JA, Y_ST, Z_JC, D_NONE, J_SEQ, 5'd0, 1'b0, 1'b0, 1'b0);
      5'd29: w = uw(PH_P2, X_JA, Y_ST, Z_JC, D_NONE, J_SEQ, 5'd0, 1'b0, 1'b0, 1'b0);
      5'd30: w = uw(PH_NONE, X_ST, Y_A, Z_ONE, D_ST, J_END, 5'd0, 1'b0, 1'b0, 1'b0);
      default: w = uw(PH_NONE, X_ST, Y_A, Z_ONE, D_NONE, J_END, 5'd0, 1'b0, 1'b0, 1'b0);
    endcase
    return w;
  endfunction

endpackage

@@ sv/lcg64_mul.sv @@
module lcg64_mul (
  input  logic        clk,
  input  logic [1:0]  phase,
  input  logic [63:0] x,
  input  logic [63:0] y,
  input  logic [63:0] z,
  output logic [63:0] acc
);

  logic [63:0] x_r, x_nxt;
  logic [63:0] y_r, y_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [31:0] ma, mb;
  logic [63:0] prod;

  always_comb begin
    case (phase)
      lcg64_pkg::PH_P0: begin
        ma = x[31:0];
        mb = y[31:0];
      end
      lcg64_pkg::PH_P1: begin
        ma = x_r[31:0];
        mb = y_r[63:32];
      end
      lcg64_pkg::PH_P2: begin
        ma = x_r[63:32];
        mb = y_r[31:0];
      end
      default: begin
        ma = x_r[31:0];
        mb = y_r[31:0];
      end
    endcase
  end

  assign prod = 64'(ma) * 64'(mb);

  always_comb begin
    x_nxt   = x_r;
    y_nxt   = y_r;
    acc_nxt = acc_r;
    case (phase)
      lcg64_pkg::PH_P0: begin
        x_nxt   = x;
        y_nxt   = y;
        acc_nxt = prod + z;
      end
      lcg64_pkg::PH_P1, lcg64_pkg::PH_P2: begin
        acc_nxt = acc_r + {prod[31:0], 32'd0};
      end
      default: begin
        acc_nxt = acc_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    acc_r <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

@@ sv/lcg64_with_jump_ahead_top.sv @@
// 64-bit linear congruential generator (x' = A * x + 1 mod 2^64) with jump-ahead.
// Input channel: in_valid/in_stall carry a command and a skip count. A draw returns
// one value on the out channel; a skip and a reseed return nothing; command 3 is
// taken and ignored. A transaction is taken whenever the block is idle, also while
// a finished result still waits in the output register.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 seed, 1 format)
// and is to be used only while the block is idle; the block itself does not enforce it.
// Datapath: each 64-bit product runs on one shared 32 x 32 multiplier (three partial
// products, then write-back), sequenced by a microcode table. A draw or a reseed
// holds in_stall while its steps run, and no new transaction is taken until it
// ends; the draw result is registered into the output register in its first step.
// A skip sets up the coefficient pairs, then for each count bit up to the top one
// composes the jump if the bit is set and squares the step, then applies the jump.
// While out_stall holds a result, the next draw waits in its first step until the
// output register frees up; other commands proceed.
// Reset (synchronous, rst_n low) restores the seed and format registers and the
// state, and clears the output valid flag and the sequencer.
module lcg64_with_jump_ahead_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [31:0] in_skip_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_value,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data
);

  logic [63:0] seed_r;
  logic [1:0]  fmt_r;
  logic [63:0] st_r, ja_r, jc_r, sa_r, sc_r;
  logic [31:0] cnt_r;
  logic        run_r;
  logic [4:0]  pc_r;
  logic        out_valid_r;
  logic [63:0] out_value_r;

  lcg64_pkg::uword_t uw;
  logic        hold;
  logic        step;
  logic        in_acc;
  logic [1:0]  mul_phase;
  logic [63:0] op_x, op_y, op_z;
  logic [63:0] mul_res;
  logic [31:0] lo_abs;
  logic [63:0] fmt_val;

  assign uw     = lcg64_pkg::ucode_rom(pc_r);
  assign hold   = uw.emit && out_valid_r && out_stall;
  assign step   = run_r && !hold;
  assign in_acc = in_valid && !run_r;

  assign mul_phase = step ? uw.phase : lcg64_pkg::PH_NONE;

  always_comb begin
    case (uw.xsel)
      lcg64_pkg::X_ST:    op_x = st_r;
      lcg64_pkg::X_NSEED: op_x = ~seed_r;
      lcg64_pkg::X_JA:    op_x = ja_r;
      default:            op_x = sa_r;
    endcase
    case (uw.ysel)
      lcg64_pkg::Y_A:  op_y = lcg64_pkg::LCG_MUL;
      lcg64_pkg::Y_SC: op_y = sc_r;
      lcg64_pkg::Y_SA: op_y = sa_r;
      default:         op_y = st_r;
    endcase
    case (uw.zsel)
      lcg64_pkg::Z_ONE: op_z = lcg64_pkg::LCG_INC;
      lcg64_pkg::Z_JC:  op_z = jc_r;
      lcg64_pkg::Z_SC:  op_z = sc_r;
      default:          op_z = 64'd0;
    endcase
  end

  lcg64_mul u_mul (
    .clk   (clk),
    .phase (mul_phase),
    .x     (op_x),
    .y     (op_y),
    .z     (op_z),
    .acc   (mul_res)
  );

  always_comb begin
    lo_abs = st_r[31] ? (32'd0 - st_r[31:0]) : st_r[31:0];
    case (fmt_r)
      lcg64_pkg::FMT_ABS32: fmt_val = {32'd0, lo_abs};
      lcg64_pkg::FMT_ABS64: fmt_val = st_r[63] ? (64'd0 - st_r) : st_r;
      default:              fmt_val = st_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= lcg64_pkg::SEED_RST;
      fmt_r  <= lcg64_pkg::FMT_ABS32;
    end else if (cfg_we) begin
      case (cfg_index)
        lcg64_pkg::REG_SEED: seed_r <= cfg_data;
        default:             fmt_r  <= cfg_data[1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      pc_r  <= lcg64_pkg::PC_DRAW;
    end else if (in_acc) begin
      case (in_command)
        lcg64_pkg::CMD_DRAW: begin
          run_r <= 1'b1;
          pc_r  <= lcg64_pkg::PC_DRAW;
        end
        lcg64_pkg::CMD_SKIP: begin
          run_r <= 1'b1;
          pc_r  <= lcg64_pkg::PC_SKIP;
        end
        lcg64_pkg::CMD_RESEED: begin
          run_r <= 1'b1;
          pc_r  <= lcg64_pkg::PC_RESEED;
        end
        default: begin
          run_r <= 1'b0;
        end
      endcase
    end else if (step) begin
      case (uw.jmp)
        lcg64_pkg::J_JZ:    pc_r <= (cnt_r == 32'd0) ? uw.target : pc_r + 5'd1;
        lcg64_pkg::J_JEVEN: pc_r <= !cnt_r[0] ? uw.target : pc_r + 5'd1;
        lcg64_pkg::J_JMP:   pc_r <= uw.target;
        lcg64_pkg::J_END:   run_r <= 1'b0;
        default:            pc_r <= pc_r + 5'd1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= lcg64_pkg::ST_RST;
      ja_r  <= 64'd0;
      jc_r  <= 64'd0;
      sa_r  <= 64'd0;
      sc_r  <= 64'd0;
      cnt_r <= 32'd0;
    end else begin
      if (in_acc && in_command == lcg64_pkg::CMD_SKIP) begin
        cnt_r <= in_skip_count;
      end else if (step && uw.shift) begin
        cnt_r <= cnt_r >> 1;
      end
      if (step && uw.init) begin
        ja_r <= 64'd1;
        jc_r <= 64'd0;
        sa_r <= lcg64_pkg::LCG_MUL;
        sc_r <= lcg64_pkg::LCG_INC;
      end
      if (step) begin
        case (uw.dst)
          lcg64_pkg::D_ST: st_r <= mul_res;
          lcg64_pkg::D_JA: ja_r <= mul_res;
          lcg64_pkg::D_JC: jc_r <= mul_res;
          lcg64_pkg::D_SA: sa_r <= mul_res;
          lcg64_pkg::D_SC: sc_r <= mul_res;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step && uw.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && uw.emit) begin
      out_value_r <= fmt_val;
    end
  end

  assign in_stall  = run_r;
  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

endmodule

@@ sv/lcg64_chk.sv @@
`include "lcg64_with_jump_ahead_top_macros.svh"

module lcg64_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  in_command,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] out_value
);

  logic in_take;
  logic out_wait;
  logic cmd_known;
  logic ignored_take;

  assign in_take      = in_valid && !in_stall;
  assign out_wait     = out_valid && out_stall;
  assign cmd_known    = in_command inside {lcg64_pkg::CMD_DRAW, lcg64_pkg::CMD_SKIP,
                                           lcg64_pkg::CMD_RESEED};
  assign ignored_take = in_take && (in_command == lcg64_pkg::CMD_IGNORED);

  `LCG64_ASSERT_NEXT(a_out_hold, out_wait, out_valid && $stable(out_value), "Held result changed.")
  `LCG64_ASSERT_NEXT(a_busy, in_take && cmd_known, in_stall, "Command left block idle.")
  `LCG64_ASSERT_SAME(a_result_from_work, $rose(out_valid), $past(in_stall), "Result while idle.")
  `LCG64_ASSERT_NEXT(a_ignored, ignored_take, !in_stall && !$rose(out_valid), "Unused command ran.")

endmodule

bind lcg64_with_jump_ahead_top lcg64_chk u_lcg64_chk (.*);

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;

  localparam logic [1:0] FMT_RAW     = 2'd2;
  localparam logic [1:0] FMT_UNUSED  = 2'd3;
  localparam int SETTLE_CYCLES = 400;
  localparam int HOLD_CYCLES   = 400;
  localparam int QUIET_LIMIT   = 5000;
  localparam int RAND_PHASES   = 16;
  localparam int PHASE_ITEMS   = 100;

  class lcg_scoreboard;
    logic [63:0] gen_state;
    logic [63:0] seed_reg;
    logic [1:0]  fmt_reg;
    logic [63:0] draws_due[$];
    int unsigned errors;
    int unsigned n_draw;
    int unsigned n_skip;
    int unsigned n_reseed;
    int unsigned n_ignored;
    int unsigned n_checked;

    function new();
      seed_reg  = 64'd1;
      fmt_reg   = lcg64_pkg::FMT_ABS32;
      gen_state = advance(~seed_reg);
      errors    = 0;
      n_draw    = 0;
      n_skip    = 0;
      n_reseed  = 0;
      n_ignored = 0;
      n_checked = 0;
    endfunction

    function logic [63:0] advance(logic [63:0] x);
      return lcg64_pkg::LCG_MUL * x + lcg64_pkg::LCG_INC;
    endfunction

    function logic [63:0] jump(logic [63:0] x, logic [31:0] n);
      logic [63:0] ja;
      logic [63:0] jc;
      logic [63:0] sa;
      logic [63:0] sc;
      ja = 64'd1;
      jc = 64'd0;
      sa = lcg64_pkg::LCG_MUL;
      sc = lcg64_pkg::LCG_INC;
      for (int i = 0; i < 32; i++) begin
        if (n[i]) begin
          jc = ja * sc + jc;
          ja = ja * sa;
        end
        sc = sa * sc + sc;
        sa = sa * sa;
      end
      return ja * x + jc;
    endfunction

    function logic [63:0] shape(logic [63:0] x);
      logic [31:0] lo;
      case (fmt_reg)
        lcg64_pkg::FMT_ABS32: begin
          lo = x[31:0];
          if (lo[31]) lo = 32'd0 - lo;
          return {32'd0, lo};
        end
        lcg64_pkg::FMT_ABS64: begin
          return x[63] ? 64'd0 - x : x;
        end
        default: return x;
      endcase
    endfunction

    function void set_reg(logic idx, logic [63:0] data);
      if (idx == lcg64_pkg::REG_SEED) seed_reg = data;
      else fmt_reg = data[1:0];
    endfunction

    function void note_input(logic [1:0] cmd, logic [31:0] count);
      case (cmd)
        lcg64_pkg::CMD_DRAW: begin
          draws_due.push_back(shape(gen_state));
          gen_state = advance(gen_state);
          n_draw++;
        end
        lcg64_pkg::CMD_SKIP: begin
          gen_state = jump(gen_state, count);
          n_skip++;
        end
        lcg64_pkg::CMD_RESEED: begin
          gen_state = advance(~seed_reg);
          n_reseed++;
        end
        default: n_ignored++;
      endcase
    endfunction

    function void check_result(logic [63:0] value);
      logic [63:0] want;
      if (draws_due.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %h", $time, value);
        errors++;
      end else begin
        want = draws_due.pop_front();
        n_checked++;
        if (value !== want) begin
          $display("%0t: value mismatch: expected %h, actual %h", $time, want, value);
          errors++;
        end
      end
    endfunction

    function int pending();
      return draws_due.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_command;
  logic [31:0] in_skip_count;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] out_value;
  logic        cfg_we;
  logic        cfg_index;
  logic [63:0] cfg_data;

  lcg_scoreboard sb;
  logic          hold_req;
  int unsigned   burst_left;
  int unsigned   quiet_cycles = 0;
  int unsigned   settings_seen;

  lcg64_with_jump_ahead_top u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_command   (in_command),
    .in_skip_count(in_skip_count),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_value    (out_value),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_input(in_command, in_skip_count);
    if (rst_n && out_valid && !out_stall) sb.check_result(out_value);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int unsigned mode;
    int unsigned mode_left;
    out_stall <= 1'b0;
    mode = 0;
    mode_left = 50;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= 1'($urandom_range(0, 1));
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(10, 200);
        end else begin
          mode_left--;
        end
      end
    end
  end

  function automatic logic [63:0] seed_for(logic [63:0] target);
    logic [63:0] inv;
    inv = lcg64_pkg::LCG_MUL;
    repeat (6) inv = inv * (64'd2 - lcg64_pkg::LCG_MUL * inv);
    return ~((target - lcg64_pkg::LCG_INC) * inv);
  endfunction

  task automatic send_item(logic [1:0] cmd, logic [31:0] count);
    in_valid      <= 1'b1;
    in_command    <= cmd;
    in_skip_count <= count;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic pause(int unsigned n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0 || in_stall) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [63:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_item();
    int unsigned pick;
    int unsigned r;
    logic [1:0]  cmd;
    logic [31:0] count;
    pick  = $urandom_range(0, 99);
    count = $urandom;
    if (pick < 62) begin
      cmd = lcg64_pkg::CMD_DRAW;
    end else if (pick < 84) begin
      cmd = lcg64_pkg::CMD_SKIP;
      r = $urandom_range(0, 9);
      if (r < 7) count = $urandom_range(0, 40);
      else if (r < 9) count = $urandom;
      else if ($urandom_range(0, 1) == 0) count = 32'hFFFF_FFFF;
      else count = 32'd1 << $urandom_range(0, 31);
    end else if (pick < 95) begin
      cmd = lcg64_pkg::CMD_RESEED;
    end else begin
      cmd = lcg64_pkg::CMD_IGNORED;
    end
    if (burst_left == 0) begin
      pause($urandom_range(1, 12));
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    send_item(cmd, count);
  endtask

  initial begin
    logic [63:0] seed_val;
    logic [1:0]  fmt_val;
    in_valid      <= 1'b0;
    in_command    <= lcg64_pkg::CMD_DRAW;
    in_skip_count <= 32'd0;
    cfg_we        <= 1'b0;
    cfg_index     <= lcg64_pkg::REG_SEED;
    cfg_data      <= 64'd0;
    rst_n         <= 1'b0;
    hold_req      = 1'b0;
    burst_left    = 0;
    settings_seen = 1;
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset state and reset registers.
    send_item(lcg64_pkg::CMD_DRAW, 32'd0);
    send_item(lcg64_pkg::CMD_DRAW, 32'hFFFF_FFFF);
    send_item(lcg64_pkg::CMD_SKIP, 32'd5);
    send_item(lcg64_pkg::CMD_DRAW, 32'd0);

    // Most negative low word in the 32-bit magnitude format.
    settle();
    write_reg(lcg64_pkg::REG_SEED, seed_for(64'h0000_0000_8000_0000));
    write_reg(lcg64_pkg::REG_FORMAT, {62'd0, lcg64_pkg::FMT_ABS32});
    send_item(lcg64_pkg::CMD_RESEED, 32'd0);
    send_item(lcg64_pkg::CMD_DRAW, 32'd0);
    send_item(lcg64_pkg::CMD_DRAW, 32'd0);

    // Most negative state in the 64-bit magnitude format.
    settle();
    write_reg(lcg64_pkg::REG_SEED, seed_for(64'h8000_0000_0000_0000));
    write_reg(lcg64_pkg::REG_FORMAT, {62'd0, lcg64_pkg::FMT_ABS64});
    send_item(lcg64_pkg::CMD_RESEED, 32'd0);
    send_item(lcg64_pkg::CMD_DRAW, 32'd0);
    send_item(lcg64_pkg::CMD_DRAW, 32'd0);

    // Raw fraction, zero and extreme skips, and the unused command.
    settle();
    write_reg(lcg64_pkg::REG_SEED, seed_for(64'hFFFF_FFFF_FFFF_FFFF));
    write_reg(lcg64_pkg::REG_FORMAT, {62'd0, FMT_RAW});
    send_item(lcg64_pkg::CMD_RESEED, 32'd0);
    send_item(lcg64_pkg::CMD_DRAW, 32'd0);
    send_item(lcg64_pkg::CMD_SKIP, 32'd0);
    send_item(lcg64_pkg::CMD_DRAW, 32'd0);
    send_item(lcg64_pkg::CMD_SKIP, 32'd1);
    send_item(lcg64_pkg::CMD_DRAW, 32'd0);
    send_item(lcg64_pkg::CMD_SKIP, 32'hFFFF_FFFF);
    send_item(lcg64_pkg::CMD_DRAW, 32'd0);
    send_item(lcg64_pkg::CMD_IGNORED, 32'hFFFF_FFFF);
    send_item(lcg64_pkg::CMD_DRAW, 32'd0);

    // The unused format reads as the raw fraction.
    settle();
    write_reg(lcg64_pkg::REG_SEED, 64'd0);
    write_reg(lcg64_pkg::REG_FORMAT, {62'd0, FMT_UNUSED});
    send_item(lcg64_pkg::CMD_RESEED, 32'd0);
    send_item(lcg64_pkg::CMD_DRAW, 32'd0);
    send_item(lcg64_pkg::CMD_SKIP, 32'h8000_0000);
    send_item(lcg64_pkg::CMD_DRAW, 32'd0);
    settings_seen += 4;

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      settle();
      if (ph == 0) seed_val = 64'hFFFF_FFFF_FFFF_FFFF;
      else if (ph == 1) seed_val = 64'd0;
      else seed_val = {$urandom, $urandom};
      if (ph < 8) fmt_val = ph[1:0];
      else fmt_val = 2'($urandom_range(0, 3));
      write_reg(lcg64_pkg::REG_SEED, seed_val);
      write_reg(lcg64_pkg::REG_FORMAT, {$urandom, 30'($urandom), fmt_val});
      settings_seen++;
      if (ph == 5) begin
        hold_req = 1'b1;
        repeat (30) send_item(lcg64_pkg::CMD_DRAW, $urandom);
      end
      repeat (PHASE_ITEMS) random_item();
    end

    settle();
    $display("covered %0d draws checked, %0d skips, %0d reseeds, %0d ignored commands",
             sb.n_checked, sb.n_skip, sb.n_reseed, sb.n_ignored);
    $display("over %0d register settings with every output format and a long output hold",
             settings_seen);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+sv
sv/lcg64_pkg.sv
sv/lcg64_mul.sv
sv/lcg64_with_jump_ahead_top.sv
sv/lcg64_chk.sv
dv/tb.sv
